FILE: sv/gaussian_sum_of_uniforms_top_macros.svh
// Assertion macros for the gaussian sum-of-uniforms block.
`ifndef GAUSSIAN_SUM_OF_UNIFORMS_TOP_MACROS_SVH
`define GAUSSIAN_SUM_OF_UNIFORMS_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define GSU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("gsu assertion failed");
`define GSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gsu assertion failed");
`else
`define GSU_ASSERT(lbl, clk, rst_n, prop)
`define GSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/gsu_pkg.sv
package gsu_pkg;

	localparam int UNIFORM_BITS_DEF = 24;
	localparam int FRAC             = 24;
	localparam int SAMPLES          = 12;
	localparam int COUNT_W          = 4;
	localparam int SUM24_W          = 28;
	localparam int DIFF_W           = 29;
	localparam int R_W              = 26;
	localparam int R2_W             = 27;
	localparam int ACC_W            = 28;
	localparam int PROD_W           = ACC_W + R2_W;
	localparam int OUT_W            = 32;
	localparam int MID_DEPTH        = 2;
	localparam int OUT_DEPTH        = 2;
	localparam int STEP_W           = 2;

	localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(SAMPLES - 1);
	localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(3);
	localparam logic signed [DIFF_W-1:0] SIX = DIFF_W'(6 * (2 ** FRAC));

	localparam logic signed [ACC_W-1:0] COEF_A = ACC_W'(66267422);
	localparam logic signed [ACC_W-1:0] COEF_B = ACC_W'(4234717);
	localparam logic signed [ACC_W-1:0] COEF_C = ACC_W'(1284177);
	localparam logic signed [ACC_W-1:0] COEF_D = ACC_W'(140190);
	localparam logic signed [ACC_W-1:0] COEF_E = ACC_W'(501635);

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SQR,
		BK_HORN,
		BK_FINAL
	} bk_state_t;

	function automatic logic signed [ACC_W-1:0] horner_coef(input logic [STEP_W-1:0] step);
		logic signed [ACC_W-1:0] c;
		case (step)
			2'd0:    c = COEF_D;
			2'd1:    c = COEF_C;
			2'd2:    c = COEF_B;
			default: c = COEF_A;
		endcase
		return c;
	endfunction

endpackage

FILE: sv/gsu_fifo.sv
`include "gaussian_sum_of_uniforms_top_macros.svh"

module gsu_fifo #(
	parameter int WIDTH = gsu_pkg::SUM24_W,
	parameter int DEPTH = gsu_pkg::MID_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`GSU_ASSERT_NEXT(a_fifo_pop_frees, clk, arst_n, do_pop && !do_push, !full)
	`GSU_ASSERT_NEXT(a_fifo_push_fills, clk, arst_n, do_push && !do_pop, !empty)

endmodule

FILE: sv/gsu_front.sv
`include "gaussian_sum_of_uniforms_top_macros.svh"

module gsu_front #(
	parameter int UNIFORM_BITS = gsu_pkg::UNIFORM_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [UNIFORM_BITS-1:0]     uniform_sample,
	output logic                        full,
	output logic                        mid_push,
	output logic [gsu_pkg::SUM24_W-1:0] mid_data,
	input  logic                        mid_full
);

	localparam int SUM_W = UNIFORM_BITS + 4;
	localparam int DN    = (UNIFORM_BITS > gsu_pkg::FRAC) ? UNIFORM_BITS - gsu_pkg::FRAC : 0;
	localparam int UP    = (UNIFORM_BITS < gsu_pkg::FRAC) ? gsu_pkg::FRAC - UNIFORM_BITS : 0;

	logic [SUM_W-1:0]             sum_q, sum_next;
	logic [gsu_pkg::COUNT_W-1:0]  count_q;
	logic                         take, last;

	assign last     = (count_q == gsu_pkg::LAST_COUNT);
	assign full     = last && mid_full;
	assign take     = push && !full;
	assign mid_push = take && last;
	assign sum_next = sum_q + SUM_W'(uniform_sample);
	assign mid_data = (UNIFORM_BITS >= gsu_pkg::FRAC)
		? gsu_pkg::SUM24_W'(sum_next >> DN)
		: gsu_pkg::SUM24_W'(sum_next) << UP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (take) begin
			if (last) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_next;
				count_q <= count_q + 1'b1;
			end
		end
	end

	`GSU_ASSERT(a_count_range, clk, arst_n, count_q <= gsu_pkg::LAST_COUNT)
	`GSU_ASSERT_NEXT(a_wrap_clears, clk, arst_n, mid_push, count_q == '0 && sum_q == '0)

endmodule

FILE: sv/gsu_back.sv
`include "gaussian_sum_of_uniforms_top_macros.svh"

module gsu_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [gsu_pkg::SUM24_W-1:0] mid_data,
	input  logic                        mid_empty,
	output logic                        mid_pop,
	output logic                        out_push,
	output logic [gsu_pkg::OUT_W-1:0]   out_data,
	input  logic                        out_full
);

	gsu_pkg::bk_state_t state_q, state_next;

	logic [gsu_pkg::STEP_W-1:0]        step_q;
	logic signed [gsu_pkg::R_W-1:0]    r_q;
	logic signed [gsu_pkg::R2_W-1:0]   r2_q;
	logic signed [gsu_pkg::ACC_W-1:0]  acc_q;
	logic signed [gsu_pkg::DIFF_W-1:0] diff;
	logic signed [gsu_pkg::ACC_W-1:0]  mul_a;
	logic signed [gsu_pkg::R2_W-1:0]   mul_b;
	logic signed [gsu_pkg::PROD_W-1:0] prod;

	assign diff     = $signed({1'b0, mid_data}) - gsu_pkg::SIX;
	assign prod     = mul_a * mul_b;
	assign out_data = {prod[gsu_pkg::PROD_W-1], prod[gsu_pkg::PROD_W-1:gsu_pkg::FRAC]};

	always_comb begin
		state_next = state_q;
		mid_pop    = 1'b0;
		out_push   = 1'b0;
		mul_a      = acc_q;
		mul_b      = {r_q[gsu_pkg::R_W-1], r_q};
		case (state_q)
			gsu_pkg::BK_IDLE: begin
				if (!mid_empty) begin
					mid_pop    = 1'b1;
					state_next = gsu_pkg::BK_SQR;
				end
			end
			gsu_pkg::BK_SQR: begin
				mul_a      = {{2{r_q[gsu_pkg::R_W-1]}}, r_q};
				state_next = gsu_pkg::BK_HORN;
			end
			gsu_pkg::BK_HORN: begin
				mul_b = r2_q;
				if (step_q == gsu_pkg::LAST_STEP) begin
					state_next = gsu_pkg::BK_FINAL;
				end
			end
			gsu_pkg::BK_FINAL: begin
				if (!out_full) begin
					out_push   = 1'b1;
					state_next = gsu_pkg::BK_IDLE;
				end
			end
			default: begin
				state_next = gsu_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsu_pkg::BK_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == gsu_pkg::BK_HORN) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gsu_pkg::BK_IDLE: begin
				if (mid_pop) begin
					r_q <= diff[gsu_pkg::R_W+1:2];
				end
			end
			gsu_pkg::BK_SQR: begin
				r2_q  <= prod[gsu_pkg::R2_W+gsu_pkg::FRAC-1:gsu_pkg::FRAC];
				acc_q <= gsu_pkg::COEF_E;
			end
			gsu_pkg::BK_HORN: begin
				acc_q <= prod[gsu_pkg::ACC_W+gsu_pkg::FRAC-1:gsu_pkg::FRAC]
					+ gsu_pkg::horner_coef(step_q);
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	`GSU_ASSERT_NEXT(a_pop_starts, clk, arst_n, mid_pop, state_q == gsu_pkg::BK_SQR)
	`GSU_ASSERT(a_step_idle, clk, arst_n, state_q == gsu_pkg::BK_HORN || step_q == '0)

endmodule

FILE: sv/gaussian_sum_of_uniforms_top.sv
// Gaussian sample generator: sum of twelve uniforms with an odd correction polynomial.
// Input channel: uniform_sample (unsigned fraction, UNIFORM_BITS bits) is taken on a
// clock edge with push high and full low. One item a cycle is taken while full stays low.
// Result channel: normal_sample (signed Q8.24) is shown while empty is low and leaves
// on an edge with pop high. One result comes from every twelve items.
// The sum of a group passes through the middle queue, the polynomial unit and the result queue.
// The polynomial unit uses one shared multiplier: it squares, runs four Horner steps
// and forms the final product, and takes the next sum only after its result is pushed.
// A two-entry queue sits between the accumulator and the polynomial unit, and a
// two-entry queue holds finished results.
// When the receiver stalls, results pile up in the result queue; once both queues
// are full, full rises on the twelfth item of the next group and holds the source.
// Reset clears the running sum, the item count and both queues; no result waits.
module gaussian_sum_of_uniforms_top #(
	parameter int UNIFORM_BITS = gsu_pkg::UNIFORM_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [UNIFORM_BITS-1:0]          uniform_sample,
	output logic                             empty,
	input  logic                             pop,
	output logic signed [gsu_pkg::OUT_W-1:0] normal_sample
);

	logic                        mid_push, mid_full, mid_pop, mid_empty;
	logic [gsu_pkg::SUM24_W-1:0] mid_wdata, mid_rdata;
	logic                        out_push, out_full;
	logic [gsu_pkg::OUT_W-1:0]   out_wdata, out_rdata;

	gsu_front #(
		.UNIFORM_BITS(UNIFORM_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.uniform_sample(uniform_sample),
		.full          (full),
		.mid_push      (mid_push),
		.mid_data      (mid_wdata),
		.mid_full      (mid_full)
	);

	gsu_fifo #(
		.WIDTH(gsu_pkg::SUM24_W),
		.DEPTH(gsu_pkg::MID_DEPTH)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (mid_wdata),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.empty (mid_empty)
	);

	gsu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_data (mid_rdata),
		.mid_empty(mid_empty),
		.mid_pop  (mid_pop),
		.out_push (out_push),
		.out_data (out_wdata),
		.out_full (out_full)
	);

	gsu_fifo #(
		.WIDTH(gsu_pkg::OUT_W),
		.DEPTH(gsu_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_wdata),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty)
	);

	assign normal_sample = $signed(out_rdata);

endmodule
